// ===== hw/rtl/dgs_pkg.sv =====
package dgs_pkg;

    localparam int MaxDims = 64;
    localparam int DimW    = $clog2(MaxDims);
    localparam int CntW    = 7;
    localparam int DivW    = 48;
    localparam int DenW    = 32;
    localparam int LogIter = 16;
    localparam logic [3:0] ExpTerms = 4'd12;

    localparam logic [31:0] Ln2Q32      = 32'd2977044472;
    localparam logic [30:0] Log2eQ30    = 31'd1549082005;
    localparam logic [19:0] Ln256Q16    = 20'd363409;
    localparam logic [19:0] LnSqrt2piQ16 = 20'd60224;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_SCORE = 1'b1
    } t_op;

    typedef struct packed {
        logic                op;
        logic [DimW-1:0]     dim_index;
        logic signed [15:0]  sample_value;
        logic signed [15:0]  mean_value;
        logic [15:0]         sigma_value;
        logic                last_element;
    } t_in_item;

    typedef struct packed {
        logic [31:0]         density;
        logic signed [31:0]  energy;
        logic                saturated;
        logic                bad_sigma;
    } t_out_item;

endpackage

// ===== hw/rtl/dgs_in_if.sv =====
interface dgs_in_if;
    logic               valid;
    logic               ready;
    dgs_pkg::t_in_item  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/dgs_out_if.sv =====
interface dgs_out_if;
    logic               valid;
    logic               ready;
    dgs_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/dgs_cfg_if.sv =====
interface dgs_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [dgs_pkg::CntW-1:0]   data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/diagonal_gaussian_scorer.sv =====
// Diagonal Gaussian scorer.
// i_cfg: one transaction writes dimension_count; always ready.
// i_in: load transactions (op 0) write mean and sigma of one dimension into
//   the table. Score transactions (op 1) bring one coordinate.
// o_out: one transaction per score item marked last: density, energy, flags.
// Steps: a score goes through table read, squares, a shared restoring divider
//   for a 48-bit quotient with the log2 squaring loop for 16 fraction bits
//   running beside it, log scaling and accumulate. Unless the energy is out of
//   range, a last score adds the exp series of 12 terms, each through the same divider.
// The input is taken only while the sequencer is idle; one item at a time.
// Reset clears the accumulator, the sigma error flag, dimension_count and the
//   output valid; the mean/sigma table is not cleared.
// A stalled receiver holds the result in the output register; the next item
//   is still taken, and a further result waits until the register frees.
module diagonal_gaussian_scorer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dgs_cfg_if.sink     i_cfg,
    dgs_in_if.sink      i_in,
    dgs_out_if.source   o_out
);

    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_READ  = 14'b00000000000010,
        S_SQ    = 14'b00000000000100,
        S_DIV   = 14'b00000000001000,
        S_LNMUL = 14'b00000000010000,
        S_ACC   = 14'b00000000100000,
        S_FIN   = 14'b00000001000000,
        S_D0    = 14'b00000010000000,
        S_D1    = 14'b00000100000000,
        S_EMUL  = 14'b00001000000000,
        S_EDIV  = 14'b00010000000000,
        S_EACC  = 14'b00100000000000,
        S_SHIFT = 14'b01000000000000,
        S_OUT   = 14'b10000000000000
    } t_state;

    t_state r_state, n_state;

    logic [dgs_pkg::CntW-1:0] r_dim_count;
    logic [31:0]              r_table [dgs_pkg::MaxDims];
    logic [31:0]              r_rd;
    logic signed [15:0]       r_x;
    logic                     r_last;
    logic                     r_contrib;
    logic [15:0]              r_ad;
    logic [15:0]              r_s;
    logic [3:0]               r_p;
    logic [30:0]              r_y;
    logic [15:0]              r_frac;
    logic [dgs_pkg::DivW-1:0] r_dv_num;
    logic [dgs_pkg::DenW-1:0] r_dv_den;
    logic [dgs_pkg::DenW-1:0] r_dv_rem;
    logic [dgs_pkg::DivW-1:0] r_dv_quo;
    logic [5:0]               r_cnt;
    logic [51:0]              r_lnprod;
    logic signed [39:0]       r_acc;
    logic                     r_err;
    logic signed [7:0]        r_n;
    logic [15:0]              r_f;
    logic [31:0]              r_ey;
    logic [33:0]              r_term;
    logic [33:0]              r_sum;
    logic [3:0]               r_k;
    logic [31:0]              r_dens;
    logic                     r_dsat;
    logic                     r_out_valid;
    dgs_pkg::t_out_item       r_out;

    logic        in_fire;
    logic        out_free;
    logic [15:0] rd_mean;
    logic [15:0] rd_sigma;
    logic signed [16:0] diff;
    logic [15:0] abs_d;
    logic [3:0]  msb_pos;
    logic [30:0] y0;
    logic [31:0] sq_ad;
    logic [31:0] sq_s;
    logic [32:0] rem_sh;
    logic        rem_ge;
    logic [31:0] rem_nx;
    logic [61:0] y_sq;
    logic [31:0] y_t;
    logic [52:0] ln_r;
    logic [19:0] ln_q16;
    logic signed [51:0] acc_sum;
    logic        acc_fits;
    logic signed [40:0] nv;
    logic signed [53:0] pb;
    logic [47:0] ey_prod;
    logic [65:0] e_prod;
    logic [34:0] up_r;
    logic [5:0]  sh;
    logic [63:0] dn_r;
    logic        e_fits;

    assign in_fire     = i_in.valid && i_in.ready;
    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign out_free    = !r_out_valid || o_out.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    assign rd_mean  = r_rd[31:16];
    assign rd_sigma = r_rd[15:0];
    assign diff     = 17'(r_x) - 17'($signed(rd_mean));
    assign abs_d    = diff[16] ? 16'(-diff) : diff[15:0];

    always_comb begin
        msb_pos = 4'd0;
        for (int i = 0; i < 16; i++) begin
            if (rd_sigma[i]) begin
                msb_pos = 4'(i);
            end
        end
    end

    assign y0    = {15'b0, rd_sigma} << (5'd30 - {1'b0, msb_pos});
    assign sq_ad = r_ad * r_ad;
    assign sq_s  = r_s * r_s;

    assign rem_sh = {r_dv_rem, r_dv_num[dgs_pkg::DivW-1]};
    assign rem_ge = rem_sh >= {1'b0, r_dv_den};
    assign rem_nx = rem_ge ? 32'(rem_sh - {1'b0, r_dv_den}) : rem_sh[31:0];

    assign y_sq = r_y * r_y;
    assign y_t  = y_sq[61:30];

    assign ln_r   = {1'b0, r_lnprod} + 53'h0_0000_8000_0000;
    assign ln_q16 = ln_r[51:32];

    assign acc_sum = $signed({4'b0, r_dv_quo}) + $signed({32'b0, ln_q16})
                   - $signed({32'b0, dgs_pkg::Ln256Q16})
                   + $signed({32'b0, dgs_pkg::LnSqrt2piQ16})
                   + $signed({{12{r_acc[39]}}, r_acc});
    assign acc_fits = (acc_sum[51:39] == {13{acc_sum[39]}});

    assign nv = -$signed({r_acc[39], r_acc});
    assign pb = $signed(nv[21:0]) * $signed({1'b0, dgs_pkg::Log2eQ30})
              + $signed({2'b01, 52'b0});

    assign ey_prod = r_f * dgs_pkg::Ln2Q32;
    assign e_prod  = r_term * r_ey;

    assign up_r = {1'b0, r_sum} << r_n[0];
    assign sh   = 6'(8'sd16 - r_n);
    assign dn_r = ({30'b0, r_sum} + (64'd1 << (sh - 6'd1))) >> sh;

    assign e_fits = (r_acc[39:31] == {9{r_acc[31]}});

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire && i_in.data.op == dgs_pkg::OP_SCORE) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                if (!r_contrib || rd_sigma == 16'd0) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_SQ;
                end
            end
            S_SQ:    n_state = S_DIV;
            S_DIV: begin
                if (r_cnt == 6'(dgs_pkg::DivW - 1)) begin
                    n_state = S_LNMUL;
                end
            end
            S_LNMUL: n_state = S_ACC;
            S_ACC:   n_state = S_FIN;
            S_FIN:   n_state = r_last ? S_D0 : S_IDLE;
            S_D0: begin
                if (nv >= 41'sd786432 || nv < -41'sd1572864) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_D1;
                end
            end
            S_D1:    n_state = S_EMUL;
            S_EMUL:  n_state = S_EDIV;
            S_EDIV: begin
                if (r_cnt == 6'(dgs_pkg::DivW - 1)) begin
                    n_state = S_EACC;
                end
            end
            S_EACC:  n_state = (r_k == dgs_pkg::ExpTerms) ? S_SHIFT : S_EMUL;
            S_SHIFT: n_state = S_OUT;
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            if (i_in.data.op == dgs_pkg::OP_LOAD) begin
                r_table[i_in.data.dim_index] <= {i_in.data.mean_value,
                                                 i_in.data.sigma_value};
            end else begin
                r_rd <= r_table[i_in.data.dim_index];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_dim_count <= '0;
            r_acc       <= '0;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid) begin
                r_dim_count <= i_cfg.data;
            end
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_x       <= i_in.data.sample_value;
                        r_last    <= i_in.data.last_element;
                        r_contrib <= {1'b0, i_in.data.dim_index} < r_dim_count;
                    end
                end
                S_READ: begin
                    if (r_contrib && rd_sigma == 16'd0) begin
                        r_err <= 1'b1;
                    end
                    r_ad <= abs_d;
                    r_s  <= rd_sigma;
                    r_p  <= msb_pos;
                    r_y  <= y0;
                end
                S_SQ: begin
                    r_dv_num <= ({16'b0, sq_ad} << 15) + 48'(sq_s[31:1]);
                    r_dv_den <= sq_s;
                    r_dv_rem <= '0;
                    r_dv_quo <= '0;
                    r_cnt    <= '0;
                    r_frac   <= '0;
                end
                S_DIV, S_EDIV: begin
                    r_dv_rem <= rem_nx;
                    r_dv_num <= r_dv_num << 1;
                    r_dv_quo <= {r_dv_quo[dgs_pkg::DivW-2:0], rem_ge};
                    r_cnt    <= r_cnt + 6'd1;
                    if (r_state == S_DIV && r_cnt < 6'(dgs_pkg::LogIter)) begin
                        r_y    <= y_t[31] ? y_t[31:1] : y_t[30:0];
                        r_frac <= {r_frac[14:0], y_t[31]};
                    end
                end
                S_LNMUL: begin
                    r_lnprod <= {r_p, r_frac} * dgs_pkg::Ln2Q32;
                end
                S_ACC: begin
                    if (acc_fits) begin
                        r_acc <= acc_sum[39:0];
                    end else begin
                        r_acc <= acc_sum[51] ? {1'b1, 39'b0} : {1'b0, {39{1'b1}}};
                    end
                end
                S_D0: begin
                    r_dsat <= (nv >= 41'sd786432);
                    if (nv >= 41'sd786432) begin
                        r_dens <= 32'hFFFF_FFFF;
                    end else if (nv < -41'sd1572864) begin
                        r_dens <= '0;
                    end else begin
                        r_n <= $signed({1'b0, pb[52:46]}) - 8'sd64;
                        r_f <= pb[45:30];
                    end
                end
                S_D1: begin
                    r_ey   <= ey_prod[47:16];
                    r_term <= 34'h1_0000_0000;
                    r_sum  <= 34'h1_0000_0000;
                    r_k    <= 4'd1;
                end
                S_EMUL: begin
                    r_dv_num <= {14'b0, e_prod[65:32]};
                    r_dv_den <= {28'b0, r_k};
                    r_dv_rem <= '0;
                    r_dv_quo <= '0;
                    r_cnt    <= '0;
                end
                S_EACC: begin
                    r_term <= r_dv_quo[33:0];
                    r_sum  <= r_sum + r_dv_quo[33:0];
                    r_k    <= r_k + 4'd1;
                end
                S_SHIFT: begin
                    if (r_n >= 8'sd16) begin
                        r_dens <= (up_r[34:32] != 3'd0) ? 32'hFFFF_FFFF : up_r[31:0];
                        r_dsat <= (up_r[34:32] != 3'd0);
                    end else begin
                        r_dens <= (dn_r[63:32] != 32'd0) ? 32'hFFFF_FFFF : dn_r[31:0];
                        r_dsat <= (dn_r[63:32] != 32'd0);
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out.density   <= r_dens;
                        r_out.energy    <= e_fits ? r_acc[31:0]
                                         : (r_acc[39] ? 32'h8000_0000 : 32'h7FFF_FFFF);
                        r_out.saturated <= r_dsat || !e_fits;
                        r_out.bad_sigma <= r_err;
                        r_acc           <= '0;
                        r_err           <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule
